FILE: hw/rtl/fbpa_pkg.sv
// Shared constants and types of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 32;
    localparam int BSL_W      = 5;
    localparam int AL_W       = 4;
    localparam int AMASK_W    = 15;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_BLOCKS);

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    // result status
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADADDR = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_POOL_START = 2'd0;
    localparam logic [1:0] REG_POOL_BYTES = 2'd1;
    localparam logic [1:0] REG_BLOCK_LOG2 = 2'd2;
    localparam logic [1:0] REG_ALIGN_LOG2 = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_start;
        logic [ADDR_W-1:0] pool_bytes;
        logic [BSL_W-1:0]  block_size_log2;
        logic [AL_W-1:0]   align_log2;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/fbpa_ctrl.sv
// Controller state machine: take an item, then commit it once the output is free.
`timescale 1ns / 1ps

module fbpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  fbpa_pkg::dp_status_t dp_status,
    output fbpa_pkg::ctrl_cmd_t  ctrl_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        ctrl_cmd.capture = 1'b0;
        ctrl_cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl_cmd.capture = 1'b1;
                    state_next       = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while the previous result still waits
                if (!dp_status.out_busy)
                begin
                    ctrl_cmd.commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/fbpa_dp.sv
// Datapath: pool geometry, free-list head, link memory, counters and result register.
`timescale 1ns / 1ps

module fbpa_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fbpa_pkg::cfg_t                      cfg,
    input  fbpa_pkg::ctrl_cmd_t                 ctrl_cmd,
    output fbpa_pkg::dp_status_t                dp_status,
    input  logic [fbpa_pkg::CMD_W-1:0]          in_command,
    input  logic [fbpa_pkg::ADDR_W-1:0]         in_free_address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fbpa_pkg::ADDR_W-1:0]         out_block_address,
    output logic [fbpa_pkg::STAT_W-1:0]         out_status,
    output logic [fbpa_pkg::CNT_W-1:0]          out_blocks_in_use
);

    localparam int AW = fbpa_pkg::ADDR_W;
    localparam int CW = fbpa_pkg::CNT_W;
    localparam int IW = fbpa_pkg::IDX_W;
    localparam int MW = fbpa_pkg::AMASK_W;

    // geometry, refreshed every cycle from the registers
    logic [AW:0]   first_reg;
    logic [CW-1:0] count_reg;
    logic [MW-1:0] amask;
    logic [MW-1:0] adj;
    logic [AW-1:0] rem;
    logic [AW-1:0] nblk;
    logic [CW-1:0] count_next;

    // item being worked on
    logic [fbpa_pkg::CMD_W-1:0] cmd_reg;
    logic [AW-1:0]              faddr_reg;

    // free list and counters
    logic [CW-1:0] head_reg;
    logic [CW-1:0] head_next;
    logic [CW-1:0] fresh_reg;
    logic [CW-1:0] fresh_next;
    logic [CW-1:0] inuse_reg;
    logic [CW-1:0] inuse_next;

    // result register
    logic                            ovalid_reg;
    logic [AW-1:0]                   oaddr_reg;
    logic [AW-1:0]                   oaddr_next;
    logic [fbpa_pkg::STAT_W-1:0]     ostat_reg;
    logic [fbpa_pkg::STAT_W-1:0]     ostat_next;
    logic [CW-1:0]                   ouse_reg;

    // link memory
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [CW-1:0] link_rdata;

    // address arithmetic
    logic [CW-1:0]   alloc_idx;
    logic [AW-1:0]   alloc_off;
    logic [AW+1:0]   fdiff;
    logic [AW-1:0]   foff;
    logic [AW-1:0]   bmask;
    logic [AW-1:0]   fidx;
    logic            free_ok;

    // geometry: adjustment to the next aligned address, then block count
    always_comb
    begin
        amask = ~({MW{1'b1}} << cfg.align_log2);
        adj   = (MW'(0) - cfg.pool_start[MW-1:0]) & amask;
        rem   = cfg.pool_bytes - AW'(adj);
        nblk  = rem >> cfg.block_size_log2;
        if (AW'(adj) > cfg.pool_bytes)
        begin
            count_next = '0;
        end
        else if (nblk > AW'(fbpa_pkg::MAX_BLOCKS))
        begin
            count_next = CW'(fbpa_pkg::MAX_BLOCKS);
        end
        else
        begin
            count_next = nblk[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= {1'b0, cfg.pool_start} + (AW+1)'(adj);
        count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            cmd_reg   <= in_command;
            faddr_reg <= in_free_address;
        end
    end

    fbpa_ram #(
        .WIDTH (CW),
        .DEPTH (fbpa_pkg::MAX_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (head_reg),
        .raddr (head_reg[IW-1:0]),
        .rdata (link_rdata)
    );

    always_comb
    begin
        alloc_idx = (head_reg != fbpa_pkg::NULL_LINK) ? head_reg : fresh_reg;
        alloc_off = AW'(alloc_idx) << cfg.block_size_log2;
        fdiff     = {2'b00, faddr_reg} - {1'b0, first_reg};
        foff      = fdiff[AW-1:0];
        bmask     = ~({AW{1'b1}} << cfg.block_size_log2);
        fidx      = foff >> cfg.block_size_log2;
        free_ok   = !fdiff[AW+1] && ((foff & bmask) == '0) && (fidx < AW'(count_reg));
    end

    always_comb
    begin
        head_next  = head_reg;
        fresh_next = fresh_reg;
        inuse_next = inuse_reg;
        oaddr_next = '0;
        ostat_next = fbpa_pkg::STAT_OK;
        link_we    = 1'b0;
        link_waddr = fidx[IW-1:0];
        case (cmd_reg)
            fbpa_pkg::CMD_ALLOC:
            begin
                if (head_reg != fbpa_pkg::NULL_LINK)
                begin
                    oaddr_next = first_reg[AW-1:0] + alloc_off;
                    head_next  = link_rdata;
                    if (inuse_reg != CW'(fbpa_pkg::MAX_BLOCKS))
                    begin
                        inuse_next = inuse_reg + CW'(1);
                    end
                end
                else if (fresh_reg < count_reg)
                begin
                    oaddr_next = first_reg[AW-1:0] + alloc_off;
                    fresh_next = fresh_reg + CW'(1);
                    if (inuse_reg != CW'(fbpa_pkg::MAX_BLOCKS))
                    begin
                        inuse_next = inuse_reg + CW'(1);
                    end
                end
                else
                begin
                    ostat_next = fbpa_pkg::STAT_EMPTY;
                end
            end
            fbpa_pkg::CMD_FREE:
            begin
                if (free_ok)
                begin
                    link_we   = ctrl_cmd.commit;
                    head_next = CW'(fidx[IW-1:0]);
                    if (inuse_reg != '0)
                    begin
                        inuse_next = inuse_reg - CW'(1);
                    end
                end
                else
                begin
                    ostat_next = fbpa_pkg::STAT_BADADDR;
                end
            end
            fbpa_pkg::CMD_RESET:
            begin
                head_next  = fbpa_pkg::NULL_LINK;
                fresh_next = '0;
                inuse_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= fbpa_pkg::NULL_LINK;
            fresh_reg  <= '0;
            inuse_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.commit)
            begin
                head_reg   <= head_next;
                fresh_reg  <= fresh_next;
                inuse_reg  <= inuse_next;
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.commit)
        begin
            oaddr_reg <= oaddr_next;
            ostat_reg <= ostat_next;
            ouse_reg  <= inuse_next;
        end
    end

    assign dp_status.out_busy = ovalid_reg && !out_ready;
    assign out_valid          = ovalid_reg;
    assign out_block_address  = oaddr_reg;
    assign out_status         = ostat_reg;
    assign out_blocks_in_use  = ouse_reg;

endmodule

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: register port, controller and datapath.
`timescale 1ns / 1ps

// Hands out fixed-size blocks from a configured byte range. The first block
// sits at pool_start rounded up to 2^align_log2; the pool holds
// (pool_bytes - adjustment) >> block_size_log2 blocks, at most 1024, and zero
// when the adjustment alone exceeds pool_bytes. An allocate pops the most
// recently freed block if there is one, else the lowest block never handed
// out; a free checks the address and pushes the block on a LIFO free list;
// a pool reset empties the list and the counters. Each item yields exactly one
// result item with the block address, a status and the blocks-in-use count.
// An item goes through an accept cycle, in which the free-list head is read
// from the link memory (1024 x 11, registered read), and a commit cycle,
// which updates the head and writes the link. The commit waits while an
// earlier result still sits unread in the output register. Derived pool
// geometry is registered from the configuration registers; the user must
// write those over the APB port only while the block is idle, which the block
// itself does not enforce. No clearing pass is needed after reset.
module fixed_block_pool_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] free_address
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] block_address, [33:32] status,
                                   // [44:34] blocks_in_use, [47:45] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fbpa_pkg::cfg_t       cfg_reg;
    fbpa_pkg::ctrl_cmd_t  ctrl_cmd;
    fbpa_pkg::dp_status_t dp_status;

    logic                          cfg_wr;
    logic [1:0]                    reg_idx;
    logic [fbpa_pkg::ADDR_W-1:0]   res_addr;
    logic [fbpa_pkg::STAT_W-1:0]   res_status;
    logic [fbpa_pkg::CNT_W-1:0]    res_in_use;

    // Register file: decode by word index, ignore the byte offset.
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_start      <= '0;
            cfg_reg.pool_bytes      <= '0;
            cfg_reg.block_size_log2 <= 5'd3;
            cfg_reg.align_log2      <= 4'd3;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                fbpa_pkg::REG_POOL_START: cfg_reg.pool_start      <= pwdata;
                fbpa_pkg::REG_POOL_BYTES: cfg_reg.pool_bytes      <= pwdata;
                fbpa_pkg::REG_BLOCK_LOG2: cfg_reg.block_size_log2 <= pwdata[4:0];
                fbpa_pkg::REG_ALIGN_LOG2: cfg_reg.align_log2      <= pwdata[3:0];
                default:                  cfg_reg.pool_start      <= cfg_reg.pool_start;
            endcase
        end
    end

    // Read back the register selected by paddr.
    always_comb
    begin
        case (reg_idx)
            fbpa_pkg::REG_POOL_START: prdata = cfg_reg.pool_start;
            fbpa_pkg::REG_POOL_BYTES: prdata = cfg_reg.pool_bytes;
            fbpa_pkg::REG_BLOCK_LOG2: prdata = {27'd0, cfg_reg.block_size_log2};
            fbpa_pkg::REG_ALIGN_LOG2: prdata = {28'd0, cfg_reg.align_log2};
            default:                  prdata = '0;
        endcase
    end

    // Sequencing: accept an item, then commit it when the output is free.
    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    // Free list, counters, address checks and the result register.
    fbpa_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .ctrl_cmd          (ctrl_cmd),
        .dp_status         (dp_status),
        .in_command        (s_tuser),
        .in_free_address   (s_tdata),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_block_address (res_addr),
        .out_status        (res_status),
        .out_blocks_in_use (res_in_use)
    );

    // Pack the result item, zero-fill to whole bytes.
    assign m_tdata = {3'b000, res_in_use, res_status, res_addr};

endmodule

FILE: tb/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for the fixed block pool allocator.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

    import fbpa_pkg::*;

    // Command code that the block must treat as a no-op.
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] free_address;
    } pool_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  blocks_in_use;
    } pool_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] free_address
    logic [1:0]  s_tuser  = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] block_address, [33:32] status,
                                  // [44:34] blocks_in_use, [47:45] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    fixed_block_pool_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Shadow of the configuration registers, updated as they are written.
    logic [ADDR_W-1:0] cfg_pool_start  = '0;
    logic [ADDR_W-1:0] cfg_pool_bytes  = '0;
    logic [BSL_W-1:0]  cfg_block_log2  = 5'd3;
    logic [AL_W-1:0]   cfg_align_log2  = 4'd3;

    // Allocator state as the testbench sees it.
    logic [CNT_W-1:0]  link_mem [MAX_BLOCKS];
    logic [CNT_W-1:0]  free_head       = NULL_LINK;
    logic [CNT_W-1:0]  fresh_count     = '0;
    logic [CNT_W-1:0]  in_use_count    = '0;

    pool_item_t   pending_items[$];
    pool_result_t expected_results[$];

    bit item_taken = 1'b0;   // set at the edge that accepts the driven item
    bit idle_on    = 1'b1;   // allow random idle bursts on both sides
    int src_gap    = 0;
    int sink_gap   = 0;
    int mismatches = 0;

    // ------------------------------------------------------------------
    // Pool geometry from the current register values
    // ------------------------------------------------------------------

    // First block: pool_start rounded up to the alignment, kept at 64 bits so
    // that a round-up past the top of the address space is not lost.
    function automatic logic [63:0] pool_base();
        logic [63:0] step;
        step = 64'd1 << cfg_align_log2;
        return ({32'd0, cfg_pool_start} + step - 64'd1) & ~(step - 64'd1);
    endfunction

    // Blocks in the pool: zero when the alignment gap alone eats the region.
    function automatic int unsigned pool_capacity();
        logic [63:0] gap;
        logic [63:0] n;
        gap = pool_base() - {32'd0, cfg_pool_start};
        if (gap > {32'd0, cfg_pool_bytes})
            return 0;
        n = ({32'd0, cfg_pool_bytes} - gap) >> cfg_block_log2;
        return (n > MAX_BLOCKS) ? MAX_BLOCKS : n[31:0];
    endfunction

    // Byte address of a block, wrapped to the address width.
    function automatic logic [ADDR_W-1:0] block_address_of(input logic [63:0] blk);
        logic [63:0] a;
        a = pool_base() + (blk << cfg_block_log2);
        return a[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Expected result of one accepted item; advances the shadow state
    // ------------------------------------------------------------------
    function automatic pool_result_t predict_pool_result(input logic [CMD_W-1:0] command,
                                                         input logic [ADDR_W-1:0] addr);
        pool_result_t r;
        logic [63:0]  base;
        logic [63:0]  offset;
        logic [63:0]  blk;
        int unsigned  total;
        bit           ok;
        r = '0;
        r.status = STAT_OK;
        case (command)
            CMD_ALLOC:
            begin
                if (free_head < NULL_LINK)
                begin
                    // pop the most recently freed block
                    r.block_address = block_address_of({53'd0, free_head});
                    free_head = link_mem[free_head[IDX_W-1:0]];
                    if (in_use_count < MAX_BLOCKS)
                        in_use_count++;
                end
                else if (fresh_count < pool_capacity())
                begin
                    // hand out the lowest block never given out
                    r.block_address = block_address_of({53'd0, fresh_count});
                    fresh_count++;
                    if (in_use_count < MAX_BLOCKS)
                        in_use_count++;
                end
                else
                begin
                    r.status = STAT_EMPTY;
                end
            end
            CMD_FREE:
            begin
                base  = pool_base();
                total = pool_capacity();
                ok    = 1'b0;
                if ({32'd0, addr} >= base)
                begin
                    offset = {32'd0, addr} - base;
                    blk    = offset >> cfg_block_log2;
                    ok = ((offset & ((64'd1 << cfg_block_log2) - 64'd1)) == 64'd0)
                         && (blk < {32'd0, total});
                end
                if (ok)
                begin
                    // push; a double free or a never-used block is accepted too
                    link_mem[blk[IDX_W-1:0]] = free_head;
                    free_head = blk[CNT_W-1:0];
                    if (in_use_count > 0)
                        in_use_count--;
                end
                else
                begin
                    r.status = STAT_BADADDR;
                end
            end
            CMD_RESET:
            begin
                free_head    = NULL_LINK;
                fresh_count  = '0;
                in_use_count = '0;
            end
            default:
            begin
            end
        endcase
        r.blocks_in_use = in_use_count;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s differs: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(input logic [CMD_W-1:0] command,
                                      input logic [ADDR_W-1:0] addr);
        pool_item_t it;
        it.command      = command;
        it.free_address = addr;
        pending_items.push_back(it);
    endfunction

    // Free address that is mostly refused: below the pool, off the block grid,
    // past the last block, or anything at all.
    function automatic logic [ADDR_W-1:0] bad_free_address();
        logic [63:0] base;
        int unsigned total;
        base  = pool_base();
        total = pool_capacity();
        case ($urandom_range(0, 3))
            0:
            begin
                if (base != 64'd0 && base <= 64'h1_0000_0000)
                    return $urandom_range(0, 32'(base - 64'd1));
                return $urandom();
            end
            1:
                return block_address_of(64'($urandom_range(0, 1023)))
                       + $urandom_range(1, (1 << cfg_block_log2) - 1);
            2:
                return block_address_of(64'(total + $urandom_range(0, 3)));
            default:
                return $urandom();
        endcase
    endfunction

    // Mostly well-formed traffic: allocates and frees of real blocks, with a
    // share of refused frees, pool resets and no-op commands mixed in.
    function automatic pool_item_t random_item(input int alloc_pct);
        pool_item_t  it;
        int unsigned total;
        int          pick;
        total = pool_capacity();
        it.free_address = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
        begin
            it.command = CMD_ALLOC;
        end
        else if (pick < 88)
        begin
            it.command = CMD_FREE;
            if (total > 0)
                it.free_address = block_address_of(64'($urandom_range(0, total - 1)));
        end
        else if (pick < 95)
        begin
            it.command      = CMD_FREE;
            it.free_address = bad_free_address();
        end
        else if (pick < 98)
        begin
            it.command = CMD_RESET;
        end
        else
        begin
            it.command = CMD_NONE;
        end
        return it;
    endfunction

    // Hold until every queued item went in and every result came out.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic reg_access(input bit is_write, input logic [1:0] index,
                              input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (!is_write && prdata !== value)
            note_mismatch("register readback", 64'(value), 64'(prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reprogram the pool while the block is idle, then read every register back.
    task automatic set_geometry(input logic [31:0] start_v, input logic [31:0] bytes_v,
                                input logic [BSL_W-1:0] bsl, input logic [AL_W-1:0] align);
        wait_drained();
        // let the last commit and the output register settle
        repeat (4) @(posedge clk);
        reg_access(1'b1, REG_POOL_START, start_v);
        reg_access(1'b1, REG_POOL_BYTES, bytes_v);
        reg_access(1'b1, REG_BLOCK_LOG2, {27'd0, bsl});
        reg_access(1'b1, REG_ALIGN_LOG2, {28'd0, align});
        cfg_pool_start = start_v;
        cfg_pool_bytes = bytes_v;
        cfg_block_log2 = bsl;
        cfg_align_log2 = align;
        reg_access(1'b0, REG_POOL_START, start_v);
        reg_access(1'b0, REG_POOL_BYTES, bytes_v);
        reg_access(1'b0, REG_BLOCK_LOG2, {27'd0, bsl});
        reg_access(1'b0, REG_ALIGN_LOG2, {28'd0, align});
    endtask

    // ------------------------------------------------------------------
    // Item driver: change inputs at the falling edge, hold valid until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : item_driver
        pool_item_t it;
        logic       hold;
        if (rst_n)
        begin
            hold = s_tvalid && !item_taken;
            item_taken = 1'b0;
            if (!hold)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    if (idle_on && $urandom_range(0, 5) == 0)
                    begin
                        // open an idle burst; this cycle is its first
                        src_gap = $urandom_range(1, 16) - 1;
                    end
                    else
                    begin
                        it = pending_items.pop_front();
                        s_tdata <= it.free_address;
                        s_tuser <= it.command;
                        hold = 1'b1;
                    end
                end
            end
            s_tvalid <= hold;
        end
    end

    // Result backpressure: random stall bursts while idling is on.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                sink_gap = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Input side: predict the result of every item the block accepts.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(predict_pool_result(s_tuser, s_tdata));
            item_taken = 1'b1;
        end
    end

    // Output side: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch("unexpected result item", 64'd0, 64'(m_tdata));
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.block_address)
                    note_mismatch("block_address", 64'(want.block_address),
                                  64'(m_tdata[31:0]));
                if (m_tdata[33:32] !== want.status)
                    note_mismatch("status", 64'(want.status), 64'(m_tdata[33:32]));
                if (m_tdata[44:34] !== want.blocks_in_use)
                    note_mismatch("blocks_in_use", 64'(want.blocks_in_use),
                                  64'(m_tdata[44:34]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned bsl;
        int unsigned align;
        int unsigned start_v;
        int unsigned bytes_v;
        int unsigned gap_v;
        int          alloc_pct;
        logic [63:0] step;
        logic [63:0] base;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry holds no blocks: allocate is refused, any free is
        // refused, and a pool reset returns all zero.
        push_item(CMD_ALLOC, 32'h0000_0000);
        push_item(CMD_FREE, 32'h0000_0000);
        push_item(CMD_RESET, 32'hFFFF_FFFF);

        // Top of the address space, largest blocks and alignment: the first
        // block rounds past 2^32, so addresses wrap and every free is refused.
        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16, 4'd12);
        push_item(CMD_ALLOC, 32'hFFFF_FFFF);
        push_item(CMD_ALLOC, 32'h0000_0000);
        push_item(CMD_FREE, 32'h0000_0000);
        push_item(CMD_FREE, 32'hFFFF_FFFF);
        push_item(CMD_ALLOC, 32'h5555_5555);

        // Pool too small: the alignment gap exceeds the region.
        set_geometry(32'h0000_0001, 32'h0000_0002, 5'd3, 4'd2);
        push_item(CMD_ALLOC, 32'h0);
        push_item(CMD_FREE, 32'h0000_0004);

        // Four 8-byte blocks: exhaust the pool, double free, refused frees
        // on every side, free of a never-used block, and the no-op command.
        set_geometry(32'h0000_1000, 32'h0000_0020, 5'd3, 4'd0);
        push_item(CMD_RESET, 32'h0);
        repeat (5) push_item(CMD_ALLOC, 32'hAAAA_AAAA);
        push_item(CMD_FREE, 32'h0000_1008);
        push_item(CMD_FREE, 32'h0000_1008);
        push_item(CMD_ALLOC, 32'h0);
        push_item(CMD_FREE, 32'h0000_1004);
        push_item(CMD_FREE, 32'h0000_0FFC);
        push_item(CMD_FREE, 32'h0000_1020);
        push_item(CMD_RESET, 32'h0);
        push_item(CMD_FREE, 32'h0000_1010);
        push_item(CMD_ALLOC, 32'h0);
        push_item(CMD_NONE, 32'h0);

        // Pool capped at 1024 blocks: mostly allocates with some refused frees and
        // no-ops, then a double free, so that later allocates hand one block out twice.
        bsl     = 4;
        align   = $urandom_range(0, 12);
        start_v = $urandom() & 32'h7FFF_FFFF;
        bytes_v = 32'h0001_0000 + $urandom_range(0, 32'hFFFF);
        set_geometry(start_v, bytes_v, BSL_W'(bsl), AL_W'(align));
        push_item(CMD_RESET, $urandom());
        repeat (1030)
        begin
            if ($urandom_range(0, 99) < 97)
                push_item(CMD_ALLOC, $urandom());
            else if ($urandom_range(0, 1) == 0)
                push_item(CMD_NONE, $urandom());
            else
                push_item(CMD_FREE, bad_free_address());
        end
        push_item(CMD_FREE, block_address_of(64'd5));
        push_item(CMD_FREE, block_address_of(64'd5));
        push_item(CMD_FREE, block_address_of(64'd9));
        repeat (6) push_item(CMD_ALLOC, $urandom());
        push_item(CMD_RESET, $urandom());

        // Random geometries with mixed traffic; the last phase runs without idling.
        for (int p = 0; p < 8; p++)
        begin
            bsl   = $urandom_range(3, 16);
            align = $urandom_range(0, 12);
            if ($urandom_range(0, 4) == 0)
                start_v = 32'hFFFF_FFFF - $urandom_range(0, 4095);
            else
                start_v = $urandom();
            step  = 64'd1 << align;
            base  = ({32'd0, start_v} + step - 64'd1) & ~(step - 64'd1);
            gap_v = 32'(base - {32'd0, start_v});
            case ($urandom_range(0, 5))
                0:       bytes_v = $urandom();
                1:       bytes_v = $urandom_range(0, gap_v);
                default: bytes_v = gap_v + ($urandom_range(1, 24) << bsl)
                                   + $urandom_range(0, (1 << bsl) - 1);
            endcase
            set_geometry(start_v, bytes_v, BSL_W'(bsl), AL_W'(align));
            idle_on   = (p != 7) && ($urandom_range(0, 3) != 0);
            alloc_pct = $urandom_range(35, 65);
            // keep listed blocks across the geometry change now and then
            if ($urandom_range(0, 2) != 0)
                push_item(CMD_RESET, $urandom());
            repeat (105) pending_items.push_back(random_item(alloc_pct));
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
